[design/c8ft_pkg.sv]
// Shared types, constants and CRC-8 function for the CRC-8 frame transmitter.
`timescale 1ns / 1ps
`default_nettype none
package c8ft_pkg;

    localparam logic [7:0] HDR_BYTE      = 8'hFF;
    localparam logic [7:0] CRC_INIT      = 8'hFF;
    localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

    // payload size codes
    localparam logic [1:0] MODE_ONE = 2'd0;
    localparam logic [1:0] MODE_TWO = 2'd1;

    localparam logic [3:0] LEN_ONE  = 4'd6;
    localparam logic [3:0] LEN_TWO  = 4'd7;
    localparam logic [3:0] LEN_FOUR = 4'd9;

    // byte positions of the identifier low and high bytes in a frame
    localparam logic [3:0] POS_ID_LO = 4'd2;
    localparam logic [3:0] POS_ID_HI = 4'd3;

    typedef struct packed {
        logic [15:0] var_id;
        logic [31:0] payload;
        logic [1:0]  mode;
    } req_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } resp_t;

    // sequencer -> CRC unit
    typedef struct packed {
        logic       init;
        logic       update;
        logic [7:0] data;
    } crc_ctl_t;

    // reflected Dallas/Maxim CRC-8, one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // frame length in bytes; bit 1 of mode selects four payload bytes
    function automatic logic [3:0] frame_len(input logic [1:0] mode);
        logic [3:0] len;
        if (mode[1]) begin
            len = LEN_FOUR;
        end else if (mode == MODE_TWO) begin
            len = LEN_TWO;
        end else begin
            len = LEN_ONE;
        end
        return len;
    endfunction

endpackage
`default_nettype wire

[design/crc8_frame_transmitter.sv]
// Top level of the CRC-8 frame transmitter: sequencer, CRC unit, output register.
//
// Usage:
//   s_ channel takes one request: var_id, payload and mode (0: one payload
//   byte, 1: two, 2 or 3: four). The m_ channel returns the frame one byte
//   per transfer: FF, FF, id low, id high, payload bytes low first, then the
//   CRC-8 (reflected 0x31, init FF) with last set.
//   Frames are 6, 7 or 9 bytes. After the request is accepted the sequencer
//   enters its send state and then loads one byte per cycle into the output
//   register while m_ready is high. Each byte passes through the single CRC
//   accumulator; s_ready is low while a frame is being sequenced.
//   The next request is taken while the final CRC byte still waits in the
//   output register.
//   When m_ready is low the output register holds its byte and the
//   sequencer and CRC unit stall in place; no byte is dropped.
//   Reset (aresetn low, synchronous) empties the output register and
//   returns the sequencer to idle; any frame in progress is abandoned.
`timescale 1ns / 1ps
`default_nettype none
module crc8_frame_transmitter
    import c8ft_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire req_t s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output resp_t     m_data
);

    logic       out_free;
    logic       emit;
    resp_t      emit_data;
    crc_ctl_t   crc_ctl;
    logic [7:0] crc;

    logic  m_valid_reg, m_valid_next;
    resp_t m_data_reg, m_data_next;

    // output register can take a byte when empty or being drained
    assign out_free = !m_valid_reg || m_ready;

    c8ft_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req       (s_data),
        .out_free  (out_free),
        .crc       (crc),
        .emit      (emit),
        .emit_data (emit_data),
        .crc_ctl   (crc_ctl)
    );

    c8ft_crc_unit u_crc (
        .aclk (aclk),
        .ctl  (crc_ctl),
        .crc  (crc)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = emit_data;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a taken request blocks the input for the following cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after a request was taken");

    // while idle, only the closing CRC byte may still be pending
    a_idle_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready && m_valid |-> m_data.last)
        else $error("idle with a non-final byte pending");

    // the byte after a frame end is empty or a header byte
    a_header_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.last |=> !m_valid || m_data.tx_byte == HDR_BYTE)
        else $error("frame did not restart with a header byte");

endmodule
`default_nettype wire

[design/c8ft_crc_unit.sv]
// CRC-8 accumulator, one byte per cycle while the sequencer asserts update.
`timescale 1ns / 1ps
`default_nettype none
module c8ft_crc_unit
    import c8ft_pkg::*;
(
    input  wire logic     aclk,
    input  wire crc_ctl_t ctl,
    output logic [7:0]    crc
);

    logic [7:0] crc_reg;
    logic [7:0] crc_next;

    always_comb begin
        crc_next = crc_reg;
        if (ctl.init) begin
            crc_next = CRC_INIT;
        end else if (ctl.update) begin
            crc_next = crc8_update(crc_reg, ctl.data);
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg <= crc_next;
    end

    assign crc = crc_reg;

endmodule
`default_nettype wire

[design/c8ft_seq.sv]
// Frame sequencer: holds the request and steps through the frame bytes.
`timescale 1ns / 1ps
`default_nettype none
module c8ft_seq
    import c8ft_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  req_valid,
    output logic       req_ready,
    input  wire req_t  req,
    input  wire logic  out_free,
    input  wire logic [7:0] crc,
    output logic       emit,
    output resp_t      emit_data,
    output crc_ctl_t   crc_ctl
);

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } state_t;

    state_t     state_reg, state_next;
    req_t       req_reg, req_next;
    logic [3:0] idx_reg, idx_next;
    logic [3:0] len_reg, len_next;
    logic [7:0] byte_sel;
    logic       is_last;
    logic       accept;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign is_last   = (idx_reg == len_reg - 4'd1);

    always_comb begin
        if (is_last) begin
            byte_sel = crc;
        end else if (idx_reg == POS_ID_LO) begin
            byte_sel = req_reg.var_id[7:0];
        end else if (idx_reg == POS_ID_HI) begin
            byte_sel = req_reg.var_id[15:8];
        end else if (idx_reg[2]) begin
            // payload byte n sits at position 4 + n
            byte_sel = req_reg.payload[8*idx_reg[1:0] +: 8];
        end else begin
            byte_sel = HDR_BYTE;
        end
    end

    assign emit              = (state_reg == ST_SEND) && out_free;
    assign emit_data.tx_byte = byte_sel;
    assign emit_data.last    = is_last;

    assign crc_ctl.init   = accept;
    assign crc_ctl.update = emit && !is_last;
    assign crc_ctl.data   = byte_sel;

    always_comb begin
        state_next = state_reg;
        req_next   = req_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SEND;
                    req_next   = req;
                    idx_next   = '0;
                    len_next   = frame_len(req.mode);
                end
            end
            ST_SEND: begin
                if (emit) begin
                    idx_next = idx_reg + 4'd1;
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            len_reg   <= LEN_ONE;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
        end
        req_reg <= req_next;
    end

endmodule
`default_nettype wire
